[rtl/core/ahfe_pkg.sv]
// Shared types, constants and helpers for the AX.25 HDLC frame encoder.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package ahfe_pkg;

  // Frame constants
  localparam int unsigned MAX_PREAMBLE = 64;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h8408;   // reflected X.25 polynomial
  localparam logic [7:0]  FLAG_OCTET   = 8'h7E;
  localparam logic [5:0]  WORD_BITS    = 6'd32;

  // Configuration port
  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;

  localparam logic [2:0] REG_DEST_CALLSIGN = 3'd0;
  localparam logic [2:0] REG_SRC_CALLSIGN  = 3'd1;
  localparam logic [2:0] REG_DEST_SSID     = 3'd2;
  localparam logic [2:0] REG_SRC_SSID      = 3'd3;
  localparam logic [2:0] REG_CONTROL       = 3'd4;
  localparam logic [2:0] REG_PID           = 3'd5;
  localparam logic [2:0] REG_PREAMBLE      = 3'd6;

  localparam logic [47:0] RST_DEST_CALLSIGN = 48'd74015710388256;
  localparam logic [47:0] RST_SRC_CALLSIGN  = 48'd35322350018592;
  localparam logic [7:0]  RST_DEST_SSID     = 8'h61;
  localparam logic [7:0]  RST_SRC_SSID      = 8'h60;
  localparam logic [7:0]  RST_CONTROL       = 8'h03;
  localparam logic [7:0]  RST_PID           = 8'hF0;
  localparam logic [6:0]  RST_PREAMBLE      = 7'd64;

  // Input item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_DATA  = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  typedef struct packed {
    logic [47:0] dest_callsign;
    logic [47:0] src_callsign;
    logic [7:0]  dest_ssid;
    logic [7:0]  src_ssid;
    logic [7:0]  control_octet;
    logic [7:0]  pid_octet;
    logic [6:0]  preamble_flags;
  } cfg_t;

  // What one encoder step puts on the line
  typedef enum logic [2:0] {
    KIND_LEAD,   // single raw zero line bit, restarts the coder state
    KIND_FLAG,   // flag octet, NRZI only
    KIND_CRC,    // stuffed octet that also feeds the CRC
    KIND_PLAIN,  // stuffed octet without CRC (FCS bytes)
    KIND_PAD     // close the frame: pad with ones, flush the last word
  } kind_t;

  // Up to ten new line bits, newest in bit 0
  typedef struct packed {
    logic [9:0] bits;
    logic [3:0] count;
  } line_bits_t;

  // Header octet by position: callsigns go out shifted left one bit
  function automatic logic [7:0] hdr_octet(input cfg_t cfg, input logic [3:0] idx);
    logic [7:0] oct;
    unique case (idx)
      4'd0:  oct = {cfg.dest_callsign[46:40], 1'b0};
      4'd1:  oct = {cfg.dest_callsign[38:32], 1'b0};
      4'd2:  oct = {cfg.dest_callsign[30:24], 1'b0};
      4'd3:  oct = {cfg.dest_callsign[22:16], 1'b0};
      4'd4:  oct = {cfg.dest_callsign[14:8], 1'b0};
      4'd5:  oct = {cfg.dest_callsign[6:0], 1'b0};
      4'd6:  oct = cfg.dest_ssid;
      4'd7:  oct = {cfg.src_callsign[46:40], 1'b0};
      4'd8:  oct = {cfg.src_callsign[38:32], 1'b0};
      4'd9:  oct = {cfg.src_callsign[30:24], 1'b0};
      4'd10: oct = {cfg.src_callsign[22:16], 1'b0};
      4'd11: oct = {cfg.src_callsign[14:8], 1'b0};
      4'd12: oct = {cfg.src_callsign[6:0], 1'b0};
      4'd13: oct = cfg.src_ssid;
      4'd14: oct = cfg.control_octet;
      4'd15: oct = cfg.pid_octet;
    endcase
    return oct;
  endfunction

endpackage

[rtl/core/ax25_hdlc_frame_encoder.sv]
// Top level of the AX.25 HDLC frame encoder: item sequencer plus coder,
// packer and configuration port. Depends on ahfe_pkg, ahfe_cfg, ahfe_octet, ahfe_pack.
`timescale 1ns / 1ps

// Usage
//   Items arrive on item_valid/item_ready with mode and data_byte: start,
//   payload byte, end. Line bits leave as 32-bit words on
//   word_valid/word_ready, earliest bit in bit 31, valid_bits leading bits
//   valid, frame_end on the last word of a frame. Header fields and the
//   flag count sit in registers on the APB-style port (8-byte stride);
//   write them only while no frame is being built.
// Throughput
//   The coder handles one octet per cycle unless the output holds it. Payload
//   bytes stream back to back. A start item codes the lead bit, the N opening
//   flags and the 16 header octets; an end item codes the two FCS octets, the
//   closing flag and the pad and flush step. Ignored items code nothing.
// Data path
//   The item enters the sequencer register and is then coded; its bits
//   land in the word register when 32 are held and one more arrives;
//   the last word of a frame is offered the cycle after the end step.
// Stalls and reset
//   When word_ready is low and a finished word waits, a step that needs to
//   emit holds and item_ready drops. Synchronous reset clears the sequencer,
//   coder state, bit accumulator and word_valid, and restores the register defaults.

module ax25_hdlc_frame_encoder (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [1:0]                    mode,
  input  logic [7:0]                    data_byte,
  // word channel
  output logic                          word_valid,
  input  logic                          word_ready,
  output logic [31:0]                   line_word,
  output logic [5:0]                    valid_bits,
  output logic [0:0]                    frame_end,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ahfe_pkg::PADDR_W-1:0]  paddr,
  input  logic [ahfe_pkg::PDATA_W-1:0]  pwdata,
  output logic [ahfe_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import ahfe_pkg::*;

  // Sequencer phases
  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_FLAG   = 3'd1;
  localparam logic [2:0] PH_HDR    = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_FCS_LO = 3'd4;
  localparam logic [2:0] PH_FCS_HI = 3'd5;
  localparam logic [2:0] PH_CLOSE  = 3'd6;
  localparam logic [2:0] PH_PAD    = 3'd7;

  cfg_t        cfg;
  logic        busy;
  logic [2:0]  phase;
  logic [5:0]  step_cnt;
  logic [7:0]  data_q;
  logic        in_frame;
  logic        accept, fire, last_step;
  logic [5:0]  flag_last;
  kind_t       kind;
  logic [7:0]  octet;
  line_bits_t  lb;
  logic [15:0] crc;

  ahfe_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Opening flag count, clamped to 1..MAX_PREAMBLE, as a last index
  always_comb begin
    if (cfg.preamble_flags == 7'd0) begin
      flag_last = 6'd0;
    end else if (cfg.preamble_flags > 7'(MAX_PREAMBLE)) begin
      flag_last = 6'(MAX_PREAMBLE - 1);
    end else begin
      flag_last = 6'(cfg.preamble_flags - 7'd1);
    end
  end

  // What the current step codes
  always_comb begin
    kind  = KIND_PAD;
    octet = FLAG_OCTET;
    unique case (phase)
      PH_LEAD:   kind = KIND_LEAD;
      PH_FLAG:   kind = KIND_FLAG;
      PH_HDR: begin
        kind  = KIND_CRC;
        octet = hdr_octet(cfg, step_cnt[3:0]);
      end
      PH_DATA: begin
        kind  = KIND_CRC;
        octet = data_q;
      end
      PH_FCS_LO: begin
        kind  = KIND_PLAIN;
        octet = ~crc[7:0];
      end
      PH_FCS_HI: begin
        kind  = KIND_PLAIN;
        octet = ~crc[15:8];
      end
      PH_CLOSE:  kind = KIND_FLAG;
      PH_PAD:    kind = KIND_PAD;
    endcase
  end

  ahfe_octet u_octet (
    .clk     (clk),
    .rst     (rst),
    .advance (fire),
    .kind    (kind),
    .octet   (octet),
    .lb      (lb),
    .crc     (crc)
  );

  ahfe_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .req        (busy),
    .kind       (kind),
    .lb         (lb),
    .fire       (fire),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .line_word  (line_word),
    .valid_bits (valid_bits),
    .frame_end  (frame_end)
  );

  assign last_step  = (phase == PH_DATA) || (phase == PH_PAD)
                   || (phase == PH_HDR && step_cnt == 6'd15);
  assign item_ready = !busy || (fire && last_step);
  assign accept     = item_valid && item_ready;

  // Item sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      phase    <= PH_LEAD;
      step_cnt <= '0;
      in_frame <= 1'b0;
    end else if (accept) begin
      step_cnt <= '0;
      unique case (mode)
        MODE_START: begin
          busy     <= 1'b1;
          phase    <= PH_LEAD;
          in_frame <= 1'b1;
        end
        MODE_DATA: begin
          busy  <= in_frame;
          phase <= PH_DATA;
        end
        MODE_END: begin
          busy     <= in_frame;
          phase    <= PH_FCS_LO;
          in_frame <= 1'b0;
        end
        default: busy <= 1'b0;
      endcase
    end else if (fire) begin
      if (last_step) busy <= 1'b0;
      unique case (phase)
        PH_LEAD: begin
          phase    <= PH_FLAG;
          step_cnt <= '0;
        end
        PH_FLAG: begin
          if (step_cnt == flag_last) begin
            phase    <= PH_HDR;
            step_cnt <= '0;
          end else begin
            step_cnt <= step_cnt + 6'd1;
          end
        end
        PH_HDR:    step_cnt <= step_cnt + 6'd1;
        PH_FCS_LO: phase    <= PH_FCS_HI;
        PH_FCS_HI: phase    <= PH_CLOSE;
        PH_CLOSE:  phase    <= PH_PAD;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) data_q <= data_byte;
  end

`ifndef SYNTHESIS
  a_ready_unless_busy: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> busy)
    else $error("item channel stalled with no item in progress");
`endif

endmodule

[rtl/core/ahfe_cfg.sv]
// APB-style configuration registers of the frame encoder.
// Depends on ahfe_pkg (cfg_t, register indexes, reset values).
`timescale 1ns / 1ps

module ahfe_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ahfe_pkg::PADDR_W-1:0]  paddr,
  input  logic [ahfe_pkg::PDATA_W-1:0]  pwdata,
  output logic [ahfe_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output ahfe_pkg::cfg_t                cfg
);
  import ahfe_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[PADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes, taken in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_callsign  <= RST_DEST_CALLSIGN;
      cfg.src_callsign   <= RST_SRC_CALLSIGN;
      cfg.dest_ssid      <= RST_DEST_SSID;
      cfg.src_ssid       <= RST_SRC_SSID;
      cfg.control_octet  <= RST_CONTROL;
      cfg.pid_octet      <= RST_PID;
      cfg.preamble_flags <= RST_PREAMBLE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEST_CALLSIGN: cfg.dest_callsign  <= pwdata[47:0];
        REG_SRC_CALLSIGN:  cfg.src_callsign   <= pwdata[47:0];
        REG_DEST_SSID:     cfg.dest_ssid      <= pwdata[7:0];
        REG_SRC_SSID:      cfg.src_ssid       <= pwdata[7:0];
        REG_CONTROL:       cfg.control_octet  <= pwdata[7:0];
        REG_PID:           cfg.pid_octet      <= pwdata[7:0];
        REG_PREAMBLE:      cfg.preamble_flags <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_DEST_CALLSIGN: prdata[47:0] = cfg.dest_callsign;
      REG_SRC_CALLSIGN:  prdata[47:0] = cfg.src_callsign;
      REG_DEST_SSID:     prdata[7:0]  = cfg.dest_ssid;
      REG_SRC_SSID:      prdata[7:0]  = cfg.src_ssid;
      REG_CONTROL:       prdata[7:0]  = cfg.control_octet;
      REG_PID:           prdata[7:0]  = cfg.pid_octet;
      REG_PREAMBLE:      prdata[6:0]  = cfg.preamble_flags;
      default:           prdata       = '0;
    endcase
  end

endmodule

[rtl/core/ahfe_octet.sv]
// One-octet line coder: CRC-16/X.25 update, bit stuffing and NRZI.
// Holds the CRC, ones count and line level. Depends on ahfe_pkg.
`timescale 1ns / 1ps

module ahfe_octet (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  ahfe_pkg::kind_t         kind,
  input  logic [7:0]              octet,
  output ahfe_pkg::line_bits_t    lb,
  output logic [15:0]             crc
);
  import ahfe_pkg::*;

  logic [15:0] crc_register, crc_register_next;
  logic [2:0]  ones_run, ones_run_next;
  logic        line_level, line_level_next;

  assign crc = crc_register;

  // Code one octet, LSB first; at most ten line bits come out
  always_comb begin
    logic       b;
    logic       fb;
    logic [9:0] acc;
    logic [3:0] n;
    b                 = 1'b0;
    fb                = 1'b0;
    acc               = '0;
    n                 = '0;
    crc_register_next = crc_register;
    ones_run_next     = ones_run;
    line_level_next   = line_level;
    unique case (kind)
      KIND_LEAD: begin
        acc               = '0;
        n                 = 4'd1;
        line_level_next   = 1'b0;
        ones_run_next     = '0;
        crc_register_next = CRC_INIT;
      end
      KIND_PAD: begin
        ones_run_next     = '0;
        crc_register_next = CRC_INIT;
      end
      KIND_FLAG: begin
        for (int i = 0; i < 8; i++) begin
          if (!FLAG_OCTET[i]) line_level_next = ~line_level_next;
          acc = {acc[8:0], line_level_next};
          n   = n + 4'd1;
        end
      end
      KIND_CRC, KIND_PLAIN: begin
        for (int i = 0; i < 8; i++) begin
          b = octet[i];
          if (kind == KIND_CRC) begin
            fb                = crc_register_next[0] ^ b;
            crc_register_next = crc_register_next >> 1;
            if (fb) crc_register_next = crc_register_next ^ CRC_POLY;
          end
          if (!b) line_level_next = ~line_level_next;
          acc = {acc[8:0], line_level_next};
          n   = n + 4'd1;
          if (b) begin
            if (ones_run_next == 3'd4) begin
              // fifth one in a row: stuffed zero toggles the line
              line_level_next = ~line_level_next;
              acc             = {acc[8:0], line_level_next};
              n               = n + 4'd1;
              ones_run_next   = '0;
            end else begin
              ones_run_next = ones_run_next + 3'd1;
            end
          end else begin
            ones_run_next = '0;
          end
        end
      end
      default: ;
    endcase
    lb.bits  = acc;
    lb.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register <= CRC_INIT;
      ones_run     <= '0;
      line_level   <= 1'b0;
    end else if (advance) begin
      crc_register <= crc_register_next;
      ones_run     <= ones_run_next;
      line_level   <= line_level_next;
    end
  end

`ifndef SYNTHESIS
  a_run_below_five: assert property (@(posedge clk) disable iff (rst)
    ones_run < 3'd5)
    else $error("ones run reached five without a stuffed zero");

  a_crc_cleared_at_close: assert property (@(posedge clk) disable iff (rst)
    advance && kind == KIND_PAD |=> crc_register == CRC_INIT)
    else $error("CRC not reinitialized after frame close");
`endif

endmodule

[rtl/core/ahfe_pack.sv]
// Line bit accumulator and 32-bit output word register.
// A full word waits until a further bit arrives. Depends on ahfe_pkg.
`timescale 1ns / 1ps

module ahfe_pack (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req,
  input  ahfe_pkg::kind_t       kind,
  input  ahfe_pkg::line_bits_t  lb,
  output logic                  fire,
  output logic                  word_valid,
  input  logic                  word_ready,
  output logic [31:0]           line_word,
  output logic [5:0]            valid_bits,
  output logic [0:0]            frame_end
);
  import ahfe_pkg::*;

  logic [31:0] pending_bits, pending_bits_next;
  logic [5:0]  pending_count, pending_count_next;

  logic [31:0] base_bits;
  logic [5:0]  base_count;
  logic [41:0] wide, shifted, rem_mask, rem_bits;
  logic [5:0]  total, rem;
  logic        over, emit, is_pad;
  logic [31:0] full_word, final_word;
  logic [5:0]  pad_count;
  logic [5:0]  lead_shift;

  assign is_pad = (kind == KIND_PAD);

  // Append the new bits; split off the oldest 32 once more than 32 are held
  always_comb begin
    base_bits  = (kind == KIND_LEAD) ? '0 : pending_bits;
    base_count = (kind == KIND_LEAD) ? '0 : pending_count;
    wide       = ({10'b0, base_bits} << lb.count) | {32'b0, lb.bits};
    total      = base_count + {2'b0, lb.count};
    over       = total > WORD_BITS;
    rem        = total - WORD_BITS;
    shifted    = wide >> rem;
    full_word  = shifted[31:0];
    rem_mask   = (42'd1 << rem) - 42'd1;
    rem_bits   = wide & rem_mask;
  end

  // Final word: ones up to the next byte boundary, left aligned
  always_comb begin
    pad_count  = {pending_count[5:3] + {2'b0, |pending_count[2:0]}, 3'b000};
    lead_shift = WORD_BITS - pending_count;
    final_word = (pending_bits << lead_shift)
               | ((32'hFFFF_FFFF >> pending_count) & ~(32'hFFFF_FFFF >> pad_count));
  end

  // A step that produces a word waits while the output register is held
  assign emit = is_pad || over;
  assign fire = req && !(emit && word_valid && !word_ready);

  always_comb begin
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    if (fire) begin
      if (is_pad) begin
        pending_bits_next  = '0;
        pending_count_next = '0;
      end else if (over) begin
        pending_bits_next  = rem_bits[31:0];
        pending_count_next = rem;
      end else begin
        pending_bits_next  = wide[31:0];
        pending_count_next = total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

  // Output register; transaction completes on word_valid && word_ready
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (fire && emit) begin
      word_valid <= 1'b1;
    end else if (word_ready) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      line_word  <= is_pad ? final_word : full_word;
      valid_bits <= is_pad ? pad_count : WORD_BITS;
      frame_end  <= is_pad;
    end
  end

`ifndef SYNTHESIS
  a_pending_fits: assert property (@(posedge clk) disable iff (rst)
    pending_count <= WORD_BITS)
    else $error("pending line bits exceed one word");

  a_whole_octets: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> valid_bits[2:0] == 3'b000 && valid_bits != 6'd0
                   && valid_bits <= WORD_BITS)
    else $error("output word not a whole number of octets");

  a_full_unless_last: assert property (@(posedge clk) disable iff (rst)
    word_valid && !frame_end |-> valid_bits == WORD_BITS)
    else $error("short word before the end of the frame");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking bench for the AX.25 HDLC frame encoder: drives frames of items,
// programs header registers over APB and checks every line word.
// Depends on ahfe_pkg and the ax25_hdlc_frame_encoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import ahfe_pkg::*;

  localparam int          CLK_HALF   = 4;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          IDLE_GAP   = 120;   // longer than the longest start item
  localparam int          PER_PHASE  = 52;
  localparam int          NUM_PHASES = 8;
  localparam logic [2:0]  REG_UNUSED = 3'd7;  // address past the register list
  localparam logic [1:0]  MODE_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
  } frame_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [5:0]  nbits;
    logic        last;
  } line_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 item_valid = 1'b0;
  logic                 item_ready;
  logic [1:0]           mode       = '0;
  logic [7:0]           data_byte  = '0;
  logic                 word_valid;
  logic                 word_ready = 1'b0;
  logic [31:0]          line_word;
  logic [5:0]           valid_bits;
  logic [0:0]           frame_end;
  logic                 psel       = 1'b0;
  logic                 penable    = 1'b0;
  logic                 pwrite     = 1'b0;
  logic [PADDR_W-1:0]   paddr      = '0;
  logic [PDATA_W-1:0]   pwdata     = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  ax25_hdlc_frame_encoder DUT (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .mode       (mode),
    .data_byte  (data_byte),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .line_word  (line_word),
    .valid_bits (valid_bits),
    .frame_end  (frame_end),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Shadow of the header registers and of the line coder
  cfg_t        hdr_cfg;
  logic [15:0] fcs_acc;
  int          ones_cnt;
  logic        line_lvl;
  logic [31:0] held_bits;
  int          held_cnt;
  logic        framing;

  line_rec_t   words_due[$];
  frame_item_t items_pending[$];
  int          items_queued = 0;
  int          items_taken  = 0;
  logic        item_taken   = 1'b0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          errs          = 0;
  int          cycles        = 0;

  // ---------------------------------------------------------------------------
  // Line coder prediction

  function automatic void emit_word(input int count, input logic last);
    line_rec_t rec;
    rec.word  = held_bits << (32 - count);
    rec.nbits = count[5:0];
    rec.last  = last;
    words_due.push_back(rec);
    held_bits = '0;
    held_cnt  = 0;
  endfunction

  // A full word stays held until the next bit shows it is not the last one
  function automatic void put_line_bit(input logic b);
    if (held_cnt >= 32) emit_word(32, 1'b0);
    held_bits = {held_bits[30:0], b};
    held_cnt++;
  endfunction

  function automatic void put_nrzi_bit(input logic b);
    if (!b) line_lvl = ~line_lvl;
    put_line_bit(line_lvl);
  endfunction

  function automatic void put_flag();
    for (int i = 0; i < 8; i++) put_nrzi_bit(FLAG_OCTET[i]);
  endfunction

  // LSB first, optional FCS update, zero inserted after five ones
  function automatic void put_stuffed(input logic [7:0] v, input logic with_fcs);
    logic b;
    logic fb;
    for (int i = 0; i < 8; i++) begin
      b = v[i];
      if (with_fcs) begin
        fb      = fcs_acc[0] ^ b;
        fcs_acc = fcs_acc >> 1;
        if (fb) fcs_acc = fcs_acc ^ CRC_POLY;
      end
      put_nrzi_bit(b);
      if (b) begin
        ones_cnt++;
        if (ones_cnt >= 5) begin
          put_nrzi_bit(1'b0);
          ones_cnt = 0;
        end
      end else begin
        ones_cnt = 0;
      end
    end
  endfunction

  function automatic void put_callsign(input logic [47:0] cs);
    logic [7:0] ch;
    for (int i = 0; i < 6; i++) begin
      ch = cs[47 - 8 * i -: 8];
      put_stuffed({ch[6:0], 1'b0}, 1'b1);
    end
  endfunction

  function automatic void encode_item(input logic [1:0] md, input logic [7:0] db);
    int          nflags;
    logic [15:0] fcs;
    case (md)
      MODE_START: begin
        fcs_acc   = CRC_INIT;
        ones_cnt  = 0;
        held_bits = '0;
        held_cnt  = 0;
        line_lvl  = 1'b0;
        framing   = 1'b1;
        put_line_bit(1'b0);
        nflags = int'(hdr_cfg.preamble_flags);
        if (nflags == 0) nflags = 1;
        if (nflags > int'(MAX_PREAMBLE)) nflags = int'(MAX_PREAMBLE);
        for (int i = 0; i < nflags; i++) put_flag();
        put_callsign(hdr_cfg.dest_callsign);
        put_stuffed(hdr_cfg.dest_ssid, 1'b1);
        put_callsign(hdr_cfg.src_callsign);
        put_stuffed(hdr_cfg.src_ssid, 1'b1);
        put_stuffed(hdr_cfg.control_octet, 1'b1);
        put_stuffed(hdr_cfg.pid_octet, 1'b1);
      end
      MODE_DATA: begin
        if (framing) put_stuffed(db, 1'b1);
      end
      MODE_END: begin
        if (framing) begin
          fcs = ~fcs_acc;
          put_stuffed(fcs[7:0], 1'b0);
          put_stuffed(fcs[15:8], 1'b0);
          put_flag();
          while ((held_cnt % 8) != 0) put_line_bit(1'b1);
          emit_word(held_cnt, 1'b1);
          framing  = 1'b0;
          ones_cnt = 0;
          fcs_acc  = CRC_INIT;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: present the next queued item at the falling edge

  always @(negedge clk) begin
    frame_item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (items_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = items_pending.pop_front();
        item_valid <= 1'b1;
        mode       <= nxt.mode;
        data_byte  <= nxt.data;
      end else begin
        item_valid <= 1'b0;
      end
    end
    word_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Rising edge: predict on accepted items, then check accepted words
  always @(posedge clk) begin
    line_rec_t exp_rec;
    item_taken <= item_valid && item_ready && !rst;
    if (!rst && item_valid && item_ready) begin
      encode_item(mode, data_byte);
      items_taken++;
    end
    if (!rst && word_valid && word_ready) begin
      if (words_due.size() == 0) begin
        errs++;
        $display("%0t: unexpected word line_word=%h valid_bits=%0d frame_end=%0d",
                 $time, line_word, valid_bits, frame_end);
      end else begin
        exp_rec = words_due.pop_front();
        if (line_word !== exp_rec.word || valid_bits !== exp_rec.nbits ||
            frame_end !== exp_rec.last) begin
          errs++;
          $display("%0t: word mismatch expected %h/%0d/%0d actual %h/%0d/%0d", $time,
                   exp_rec.word, exp_rec.nbits, exp_rec.last,
                   line_word, valid_bits, frame_end);
        end
      end
    end
  end

  // Run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers

  task automatic queue_item(input logic [1:0] md, input logic [7:0] db);
    frame_item_t it;
    it.mode = md;
    it.data = db;
    items_pending.push_back(it);
    items_queued++;
  endtask

  // Wait until every item is taken and every predicted word has come out
  task automatic settle(input int extra);
    while (items_taken != items_queued || words_due.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DEST_CALLSIGN: hdr_cfg.dest_callsign  = val[47:0];
      REG_SRC_CALLSIGN:  hdr_cfg.src_callsign   = val[47:0];
      REG_DEST_SSID:     hdr_cfg.dest_ssid      = val[7:0];
      REG_SRC_SSID:      hdr_cfg.src_ssid       = val[7:0];
      REG_CONTROL:       hdr_cfg.control_octet  = val[7:0];
      REG_PID:           hdr_cfg.pid_octet      = val[7:0];
      REG_PREAMBLE:      hdr_cfg.preamble_flags = val[6:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    case ($urandom_range(5))
      0:       v = 8'hFF;
      1:       v = FLAG_OCTET;
      2:       v = ($urandom_range(1) != 0) ? 8'h1F : 8'hF8;
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  function automatic logic [47:0] pick_callsign();
    logic [47:0] v;
    case ($urandom_range(4))
      0:       v = '0;
      1:       v = '1;
      default: v = 48'({$urandom, $urandom});
    endcase
    return v;
  endfunction

  // Random header setup; upper bus bits (but for the control write) carry junk the register must drop
  task automatic program_header(input int ph);
    logic [63:0] junk;
    logic [6:0]  flags;
    junk = {$urandom, $urandom};
    case (ph)
      2:       flags = 7'd64;
      5:       flags = 7'd0;
      6:       flags = 7'h7F;
      default: flags = 7'($urandom_range(1, 5));
    endcase
    write_reg(REG_DEST_CALLSIGN, {junk[15:0], pick_callsign()});
    write_reg(REG_SRC_CALLSIGN,  {junk[31:16], pick_callsign()});
    write_reg(REG_DEST_SSID,     {junk[63:8], 8'($urandom_range(255))});
    write_reg(REG_SRC_SSID,      {junk[55:0], 8'($urandom_range(255))});
    write_reg(REG_CONTROL,       {56'd0, pick_byte()});
    write_reg(REG_PID,           {junk[62:7], 8'($urandom_range(255))});
    write_reg(REG_PREAMBLE,      {junk[56:0], flags});
  endtask

  // One frame, mostly short; now and then a restart or a stray item inside
  task automatic queue_frame(inout int counted);
    int n;
    queue_item(MODE_START, 8'($urandom_range(255)));
    counted++;
    n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(39))
        0: queue_item(MODE_NONE, 8'($urandom_range(255)));
        1: begin
          queue_item(MODE_START, 8'($urandom_range(255)));
          counted++;
        end
        default: begin
          queue_item(MODE_DATA, pick_byte());
          counted++;
        end
      endcase
    end
    queue_item(MODE_END, 8'($urandom_range(255)));
    counted++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence

  initial begin
    int counted;
    hdr_cfg.dest_callsign  = RST_DEST_CALLSIGN;
    hdr_cfg.src_callsign   = RST_SRC_CALLSIGN;
    hdr_cfg.dest_ssid      = RST_DEST_SSID;
    hdr_cfg.src_ssid       = RST_SRC_SSID;
    hdr_cfg.control_octet  = RST_CONTROL;
    hdr_cfg.pid_octet      = RST_PID;
    hdr_cfg.preamble_flags = RST_PREAMBLE;
    fcs_acc   = CRC_INIT;
    ones_cnt  = 0;
    line_lvl  = 1'b0;
    held_bits = '0;
    held_cnt  = 0;
    framing   = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default header: ignored items, stuffing extremes, a mid-frame pause
    queue_item(MODE_NONE, 8'hFF);
    queue_item(MODE_DATA, 8'h55);
    queue_item(MODE_END, 8'h00);
    queue_item(MODE_START, 8'h00);
    queue_item(MODE_DATA, 8'h00);
    queue_item(MODE_DATA, 8'hFF);
    queue_item(MODE_DATA, 8'hFF);
    settle(0);
    queue_item(MODE_DATA, FLAG_OCTET);
    queue_item(MODE_END, 8'hFF);
    // restart while a frame is open
    queue_item(MODE_START, 8'h00);
    queue_item(MODE_DATA, 8'hAA);
    queue_item(MODE_START, 8'h00);
    queue_item(MODE_DATA, 8'h01);
    queue_item(MODE_END, 8'h00);
    settle(IDLE_GAP);

    // Extreme header values, zero flag count, write past the register list
    write_reg(REG_DEST_CALLSIGN, 64'h0000_FFFF_FFFF_FFFF);
    write_reg(REG_SRC_CALLSIGN,  64'h0);
    write_reg(REG_DEST_SSID,     64'hFF);
    write_reg(REG_SRC_SSID,      64'h00);
    write_reg(REG_CONTROL,       64'hFF);
    write_reg(REG_PID,           64'h00);
    write_reg(REG_PREAMBLE,      64'h0);
    write_reg(REG_UNUSED,        64'hFFFF_FFFF_FFFF_FFFF);
    queue_item(MODE_START, 8'h00);
    queue_item(MODE_END, 8'h00);
    queue_item(MODE_START, 8'h00);
    queue_item(MODE_DATA, 8'h80);
    queue_item(MODE_END, 8'h00);
    settle(IDLE_GAP);

    // Flag count above the maximum, swapped callsign extremes
    write_reg(REG_DEST_CALLSIGN, 64'h0);
    write_reg(REG_SRC_CALLSIGN,  64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PREAMBLE,      64'h7F);
    queue_item(MODE_START, 8'h00);
    queue_item(MODE_DATA, 8'h7F);
    queue_item(MODE_END, 8'h00);
    settle(IDLE_GAP);

    // Random frames under each idling pattern
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 63; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      program_header(ph);
      counted = 0;
      while (counted < PER_PHASE) begin
        if ($urandom_range(99) < 8) begin
          // stray items between frames, all ignored
          case ($urandom_range(2))
            0:       queue_item(MODE_NONE, 8'($urandom_range(255)));
            1:       queue_item(MODE_DATA, 8'($urandom_range(255)));
            default: queue_item(MODE_END, 8'($urandom_range(255)));
          endcase
        end else begin
          queue_frame(counted);
        end
      end
      settle(IDLE_GAP);
    end

    settle(IDLE_GAP);
    if (errs == 0 && words_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[ax25_hdlc_frame_encoder.f]
rtl/core/ahfe_pkg.sv
rtl/core/ahfe_cfg.sv
rtl/core/ahfe_octet.sv
rtl/core/ahfe_pack.sv
rtl/core/ax25_hdlc_frame_encoder.sv
tb/tb_top.sv
